[sv/pcfd_pkg.sv]
// Package for the filtered-derivative PID controller: widths, codes, micro-op
// encodings, the microcode ROM and the saturating arithmetic helpers.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package pcfd_pkg;

  // Fixed field widths and fixed-point formats.
  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ALPHA_W    = 16;
  localparam int ALPHA_BITS = 16;
  localparam int CMD_W      = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int SUM_W      = DATA_W + 2;
  localparam int OPND_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int SHR_W      = PROD_W - FRAC_BITS;
  localparam int PC_W       = 4;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Reset values of the limit registers: -1.0 and +1.0.
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -(DATA_W'(1) <<< FRAC_BITS);
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = DATA_W'(1) <<< FRAC_BITS;

  // Commands carried by an input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_COMPUTE = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_LOAD    = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INT_GAIN   = 3'd1,
    REG_DER_GAIN   = 3'd2,
    REG_ALPHA      = 3'd3,
    REG_OUT_MIN    = 3'd4,
    REG_OUT_MAX    = 3'd5,
    REG_DERIV_MEAS = 3'd6
  } cfg_reg_t;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    UOP_NONE = 4'd0,
    UOP_ERR  = 4'd1,
    UOP_PREP = 4'd2,
    UOP_PVAL = 4'd3,
    UOP_INTG = 4'd4,
    UOP_DRAW = 4'd5,
    UOP_AVAL = 4'd6,
    UOP_FILT = 4'd7,
    UOP_OUT  = 4'd8,
    UOP_CLR  = 4'd9,
    UOP_LOAD = 4'd10,
    UOP_HOLD = 4'd11
  } uop_t;

  // Operand pair for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_P     = 3'd1,
    MUL_I     = 3'd2,
    MUL_D     = 3'd3,
    MUL_KEEP  = 3'd4,
    MUL_ALPHA = 3'd5
  } mul_sel_t;

  // One control word of the sequencer.
  typedef struct packed {
    uop_t            uop;
    mul_sel_t        mul;
    logic            skip;    // jump to target when the filter is bypassed
    logic [PC_W-1:0] target;
    logic            last;    // final step: delivers the result word
  } ucw_t;

  // Program addresses.
  localparam logic [PC_W-1:0] PC_ERR  = 4'd0;
  localparam logic [PC_W-1:0] PC_PREP = 4'd1;
  localparam logic [PC_W-1:0] PC_PVAL = 4'd2;
  localparam logic [PC_W-1:0] PC_INTG = 4'd3;
  localparam logic [PC_W-1:0] PC_DRAW = 4'd4;
  localparam logic [PC_W-1:0] PC_KEEP = 4'd5;
  localparam logic [PC_W-1:0] PC_AVAL = 4'd6;
  localparam logic [PC_W-1:0] PC_FILT = 4'd7;
  localparam logic [PC_W-1:0] PC_OUT  = 4'd8;
  localparam logic [PC_W-1:0] PC_CLR  = 4'd9;
  localparam logic [PC_W-1:0] PC_LOAD = 4'd10;
  localparam logic [PC_W-1:0] PC_HOLD = 4'd11;
  localparam logic [PC_W-1:0] PC_LAST = PC_HOLD;

  // Microcode ROM.
  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{UOP_HOLD, MUL_NONE, 1'b0, PC_HOLD, 1'b1};
    case (pc)
      PC_ERR:  w = '{UOP_ERR,  MUL_NONE,  1'b0, PC_ERR, 1'b0};
      PC_PREP: w = '{UOP_PREP, MUL_P,     1'b0, PC_ERR, 1'b0};
      PC_PVAL: w = '{UOP_PVAL, MUL_I,     1'b0, PC_ERR, 1'b0};
      PC_INTG: w = '{UOP_INTG, MUL_D,     1'b0, PC_ERR, 1'b0};
      PC_DRAW: w = '{UOP_DRAW, MUL_NONE,  1'b1, PC_OUT, 1'b0};
      PC_KEEP: w = '{UOP_NONE, MUL_KEEP,  1'b0, PC_ERR, 1'b0};
      PC_AVAL: w = '{UOP_AVAL, MUL_ALPHA, 1'b0, PC_ERR, 1'b0};
      PC_FILT: w = '{UOP_FILT, MUL_NONE,  1'b0, PC_ERR, 1'b0};
      PC_OUT:  w = '{UOP_OUT,  MUL_NONE,  1'b0, PC_ERR, 1'b1};
      PC_CLR:  w = '{UOP_CLR,  MUL_NONE,  1'b0, PC_ERR, 1'b1};
      PC_LOAD: w = '{UOP_LOAD, MUL_NONE,  1'b0, PC_ERR, 1'b1};
      PC_HOLD: w = '{UOP_HOLD, MUL_NONE,  1'b0, PC_ERR, 1'b1};
      default: w = '{UOP_HOLD, MUL_NONE,  1'b0, PC_ERR, 1'b1};
    endcase
    return w;
  endfunction

  // Entry point of the program for each command.
  function automatic logic [PC_W-1:0] ucode_entry(input logic [CMD_W-1:0] cmd);
    logic [PC_W-1:0] pc;
    case (cmd)
      CMD_COMPUTE: pc = PC_ERR;
      CMD_CLEAR:   pc = PC_CLR;
      CMD_LOAD:    pc = PC_LOAD;
      default:     pc = PC_HOLD;
    endcase
    return pc;
  endfunction

  // Saturate a sum that carries two guard bits.
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
    logic signed [DATA_W-1:0] y;
    if (x[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){1'b0}} ||
        x[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){1'b1}}) begin
      y = x[DATA_W-1:0];
    end else begin
      y = x[SUM_W-1] ? DATA_MIN : DATA_MAX;
    end
    return y;
  endfunction

  // Saturating add and subtract of two data words.
  function automatic logic signed [DATA_W-1:0] sadd(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = {{2{a[DATA_W-1]}}, a} + {{2{b[DATA_W-1]}}, b};
    return sat_sum(s);
  endfunction

  function automatic logic signed [DATA_W-1:0] ssub(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = {{2{a[DATA_W-1]}}, a} - {{2{b[DATA_W-1]}}, b};
    return sat_sum(s);
  endfunction

  // Saturate a shifted product to the data range.
  function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [SHR_W-1:0] x);
    logic signed [DATA_W-1:0] y;
    if (x[SHR_W-1:DATA_W-1] == {(SHR_W-DATA_W+1){1'b0}} ||
        x[SHR_W-1:DATA_W-1] == {(SHR_W-DATA_W+1){1'b1}}) begin
      y = x[DATA_W-1:0];
    end else begin
      y = x[SHR_W-1] ? DATA_MIN : DATA_MAX;
    end
    return y;
  endfunction

endpackage

[sv/pcfd_ifs.sv]
// Handshake channel interfaces of the PID controller: input words, result
// words and configuration writes. Depends on pcfd_pkg.
`timescale 1ns / 1ps

interface pcfd_in_if
  import pcfd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measurement;
  logic signed [DATA_W-1:0] integrator_load;

  modport source (output valid, cmd, setpoint, measurement, integrator_load, input ready);
  modport sink   (input valid, cmd, setpoint, measurement, integrator_load, output ready);
endinterface

interface pcfd_out_if
  import pcfd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] control_output;
  logic signed [DATA_W-1:0] integrator_now;

  modport source (output valid, control_output, integrator_now, input ready);
  modport sink   (input valid, control_output, integrator_now, output ready);
endinterface

interface pcfd_cfg_if
  import pcfd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [DATA_W-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[sv/pid_controller_filtered_derivative_top.sv]
// Top level of the Q16.16 PID controller with trapezoidal integral and
// filtered derivative: microcoded sequencer, shared multiplier, state.
// Depends on pcfd_pkg and the channel interfaces in pcfd_ifs.sv.
//
//   Channel  Direction  Word contents
//   in_ch    sink       cmd, setpoint, measurement, integrator_load
//   out_ch   source     control_output, integrator_now
//   cfg_ch   sink       addr (register index), data
//
// A compute word runs the steps from the error to the output word and skips
// the filter steps on the first sample or with the filter off; clear, load
// and unused commands run only a final step. The step program is shaped by
// the one shared multiplier, used at most once per step, product registered.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the controller state. A stalled result word holds the final step until the
// output register frees; a new word is taken while a result still waits.
`timescale 1ns / 1ps

module pid_controller_filtered_derivative_top
  import pcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  pcfd_in_if.sink    in_ch,
  pcfd_out_if.source out_ch,
  pcfd_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r, omin_r, omax_r;
  logic [ALPHA_W-1:0]       alpha_r;
  logic                     dom_r;

  // Controller state.
  logic signed [DATA_W-1:0] integ_r, perr_r, pmeas_r, fd_r;
  logic                     first_r;

  // Captured input word and intermediate values.
  logic signed [DATA_W-1:0] sp_r, meas_r, load_r;
  logic signed [DATA_W-1:0] err_r, esum_r, din_r, p_r, itmp_r, imax_r, imin_r, d_r, a_r;
  logic signed [PROD_W-1:0] prod_r;

  // Sequencer.
  logic            busy_r;
  logic [PC_W-1:0] pc_r;
  ucw_t            cw;

  // Result register.
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] ctrl_out_r, integ_out_r;

  logic                     in_fire, out_free, step_go, emit, skip_filt;
  logic signed [PROD_W-1:0] prod_shf, prod_sha;
  logic signed [DATA_W-1:0] prod_q, prod_a, itmp_c, diff_max, diff_min, out_sum;
  logic signed [SUM_W-1:0]  sum3;
  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic [ALPHA_BITS:0]      keep;

  // Handshakes and step control.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !busy_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cw           = ucode_rom(pc_r);
  assign step_go      = busy_r && (!cw.last || out_free);
  assign emit         = busy_r && cw.last && out_free;
  assign skip_filt    = first_r || (alpha_r == '0);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.control_output = ctrl_out_r;
  assign out_ch.integrator_now = integ_out_r;

  // Product scaling: floor shift by the fraction width, then saturation.
  assign prod_shf = prod_r >>> FRAC_BITS;
  assign prod_q   = sat_prod(prod_shf[SHR_W-1:0]);
  // Filter products never exceed the data range after the shift.
  assign prod_sha = prod_r >>> ALPHA_BITS;
  assign prod_a   = prod_sha[DATA_W-1:0];

  // Integrator clamp bounds and the output sum.
  assign itmp_c   = itmp_r;
  assign diff_max = ssub(omax_r, p_r);
  assign diff_min = ssub(omin_r, p_r);
  assign sum3     = {{2{p_r[DATA_W-1]}}, p_r} + {{2{integ_r[DATA_W-1]}}, integ_r}
                  + {{2{d_r[DATA_W-1]}}, d_r};
  assign out_sum  = sat_sum(sum3);

  // Multiplier operand selection.
  assign keep = (ALPHA_BITS+1)'(1) << ALPHA_BITS;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.mul)
      MUL_P: begin
        mul_a = OPND_W'(kp_r);
        mul_b = OPND_W'(err_r);
      end
      MUL_I: begin
        mul_a = OPND_W'(ki_r);
        mul_b = OPND_W'(esum_r);
      end
      MUL_D: begin
        mul_a = OPND_W'(kd_r);
        mul_b = OPND_W'(din_r);
      end
      MUL_KEEP: begin
        mul_a = $signed(OPND_W'(keep - (ALPHA_BITS+1)'(alpha_r)));
        mul_b = OPND_W'(fd_r);
      end
      MUL_ALPHA: begin
        mul_a = $signed(OPND_W'(alpha_r));
        mul_b = OPND_W'(d_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      alpha_r <= '0;
      omin_r  <= OUT_MIN_RST;
      omax_r  <= OUT_MAX_RST;
      dom_r   <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.addr)
        REG_PROP_GAIN:  kp_r    <= cfg_ch.data;
        REG_INT_GAIN:   ki_r    <= cfg_ch.data;
        REG_DER_GAIN:   kd_r    <= cfg_ch.data;
        REG_ALPHA:      alpha_r <= cfg_ch.data[ALPHA_W-1:0];
        REG_OUT_MIN:    omin_r  <= cfg_ch.data;
        REG_OUT_MAX:    omax_r  <= cfg_ch.data;
        REG_DERIV_MEAS: dom_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: step counter with one conditional jump.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_HOLD;
    end else if (in_fire) begin
      busy_r <= 1'b1;
      pc_r   <= ucode_entry(in_ch.cmd);
    end else if (emit) begin
      busy_r <= 1'b0;
    end else if (step_go) begin
      pc_r <= (cw.skip && skip_filt) ? cw.target : pc_r + PC_W'(1);
    end
  end

  // Captured input fields.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sp_r   <= in_ch.setpoint;
      meas_r <= in_ch.measurement;
      load_r <= in_ch.integrator_load;
    end
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    if (step_go && cw.mul != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Datapath intermediates.
  always_ff @(posedge clk) begin
    if (step_go) begin
      case (cw.uop)
        UOP_ERR: err_r <= ssub(sp_r, meas_r);
        UOP_PREP: begin
          esum_r <= sadd(err_r, perr_r);
          din_r  <= dom_r ? ssub(pmeas_r, meas_r) : ssub(err_r, perr_r);
        end
        UOP_PVAL: p_r <= prod_q;
        UOP_INTG: begin
          itmp_r <= sadd(integ_r, prod_q);
          imax_r <= diff_max[DATA_W-1] ? '0 : diff_max;
          imin_r <= diff_min[DATA_W-1] ? diff_min : '0;
        end
        UOP_DRAW: d_r <= first_r ? '0 : prod_q;
        UOP_AVAL: a_r <= prod_a;
        UOP_FILT: d_r <= sadd(a_r, prod_a);
        default: ;
      endcase
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      perr_r  <= '0;
      pmeas_r <= '0;
      fd_r    <= '0;
      first_r <= 1'b1;
    end else if (step_go) begin
      case (cw.uop)
        UOP_DRAW: begin
          if (itmp_c < imin_r) begin
            integ_r <= imin_r;
          end else if (itmp_c > imax_r) begin
            integ_r <= imax_r;
          end else begin
            integ_r <= itmp_c;
          end
        end
        UOP_FILT: fd_r <= sadd(a_r, prod_a);
        UOP_OUT: begin
          perr_r  <= err_r;
          pmeas_r <= meas_r;
          first_r <= 1'b0;
        end
        UOP_CLR: begin
          integ_r <= '0;
          perr_r  <= '0;
          pmeas_r <= '0;
          fd_r    <= '0;
          first_r <= 1'b1;
        end
        UOP_LOAD: integ_r <= load_r;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result word contents; only a compute word carries a nonzero output.
  always_ff @(posedge clk) begin
    if (emit) begin
      case (cw.uop)
        UOP_OUT: begin
          integ_out_r <= integ_r;
          if (out_sum < omin_r) begin
            ctrl_out_r <= omin_r;
          end else if (out_sum > omax_r) begin
            ctrl_out_r <= omax_r;
          end else begin
            ctrl_out_r <= out_sum;
          end
        end
        UOP_CLR: begin
          integ_out_r <= '0;
          ctrl_out_r  <= '0;
        end
        UOP_LOAD: begin
          integ_out_r <= load_r;
          ctrl_out_r  <= '0;
        end
        default: begin
          integ_out_r <= integ_r;
          ctrl_out_r  <= '0;
        end
      endcase
    end
  end

`ifndef SYNTH
  // No word is taken while a program runs.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ch.ready)
    else $error("input accepted while sequencer busy");

  // The step counter never leaves the program.
  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= PC_LAST)
    else $error("step counter outside program");

  // A clear command leaves a zero integrator and a pending first sample.
  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cw.uop == UOP_CLR) |=> (integ_r == '0 && first_r))
    else $error("clear left stale state");

  // A finished compute step ends the first-sample phase.
  a_first_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cw.uop == UOP_OUT) |=> !first_r)
    else $error("first sample flag not cleared");

  // Each delivered result leaves a word in the output register.
  a_emit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("result word lost");
`endif

endmodule
